// ===== rtl/core/sedf_pkg.sv =====
// Shared types, constants and limits for the signed envelope deframer.
package sedf_pkg;

    // Width of the in-frame byte position counter.
    localparam int COUNTER_BITS = 32;

    // Largest value the position counter can hold.
    localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNTER_BITS) - 64'd1);

    // Envelope layout.
    localparam int HDR_BYTES  = 81;
    localparam int LEN_OFFSET = 12;
    localparam int LEN_BYTES  = 4;

    // Configuration register indexes.
    localparam logic CFG_EXP_VER   = 1'b0;
    localparam logic CFG_MAX_BYTES = 1'b1;

    // Configuration reset values.
    localparam logic [7:0]  EXP_VER_RST   = 8'd1;
    localparam logic [31:0] MAX_BYTES_RST = 32'(1024 * 1024 * 10);

    typedef enum logic [1:0] {
        SEC_HEADER  = 2'd0,
        SEC_PAYLOAD = 2'd1,
        SEC_SIGLEN  = 2'd2,
        SEC_SIG     = 2'd3
    } t_sec;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_VERSION  = 2'd1,
        ERR_TOO_LONG = 2'd2
    } t_err;

    // One tagged output beat.
    typedef struct packed {
        logic [7:0] out_byte;
        t_sec       section;
        logic       first_of_frame;
        logic       last_of_frame;
        t_err       error_code;
    } t_result;

    // Configuration values seen by the parser.
    typedef struct packed {
        logic [7:0]  exp_ver;
        logic [31:0] max_bytes;
    } t_cfg;

endpackage

// ===== rtl/core/sedf_in_stage.sv =====
// Input register stage that holds one received byte for the parser.
module sedf_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    input  logic       i_take,
    output logic [7:0] o_byte
);
    import sedf_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    // The stage can load when it is empty or its byte leaves this cycle.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== rtl/core/sedf_parser.sv =====
// Frame state tracker that tags each byte with section, marks and errors.
module sedf_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  sedf_pkg::t_cfg    i_cfg,
    output sedf_pkg::t_result o_result
);
    import sedf_pkg::*;

    localparam logic [COUNTER_BITS-1:0] POS_ZERO = '0;
    localparam logic [COUNTER_BITS-1:0] POS_ONE  = COUNTER_BITS'(1);

    t_sec                    r_sec,       n_sec;
    logic [COUNTER_BITS-1:0] r_pos,       n_pos;
    logic [31:0]             r_plen,      n_plen;
    logic [31:0]             r_siglen,    n_siglen;
    logic [32:0]             r_pay_end,   n_pay_end;
    logic [32:0]             r_siglen_end, n_siglen_end;
    logic [32:0]             r_base,      n_base;
    logic [33:0]             r_sig_end,   n_sig_end;

    logic [31:0] limit;
    logic [33:0] pos_x;
    logic [32:0] hdr_total;
    logic [33:0] frame_total;
    logic        first, last, adv;
    t_err        err;

    assign limit = (i_cfg.max_bytes > CNT_MAX) ? CNT_MAX : i_cfg.max_bytes;
    assign pos_x = 34'(r_pos);

    always_comb begin
        n_sec     = r_sec;
        n_pos     = r_pos;
        n_plen    = r_plen;
        n_siglen  = r_siglen;
        first     = 1'b0;
        last      = 1'b0;
        err       = ERR_NONE;
        adv       = 1'b1;
        hdr_total   = '0;
        frame_total = '0;

        case (r_sec)
            SEC_HEADER: begin
                if (r_pos == POS_ZERO) begin
                    if (i_byte != i_cfg.exp_ver) begin
                        err = ERR_VERSION;
                        adv = 1'b0;
                    end else begin
                        first    = 1'b1;
                        n_plen   = '0;
                        n_siglen = '0;
                    end
                end else if (pos_x >= 34'(LEN_OFFSET) &&
                             pos_x < 34'(LEN_OFFSET + LEN_BYTES)) begin
                    n_plen    = {r_plen[23:0], i_byte};
                    hdr_total = 33'(HDR_BYTES + LEN_BYTES) + 33'(n_plen);
                    if (pos_x == 34'(LEN_OFFSET + LEN_BYTES - 1) &&
                        hdr_total > 33'(limit)) begin
                        err   = ERR_TOO_LONG;
                        n_sec = SEC_HEADER;
                        n_pos = POS_ZERO;
                        adv   = 1'b0;
                    end
                end
                if (adv && pos_x == 34'(HDR_BYTES - 1)) begin
                    n_sec = (n_plen != '0) ? SEC_PAYLOAD : SEC_SIGLEN;
                end
            end
            SEC_PAYLOAD: begin
                if (pos_x >= 34'(r_pay_end)) begin
                    n_sec = SEC_SIGLEN;
                end
            end
            SEC_SIGLEN: begin
                n_siglen    = {r_siglen[23:0], i_byte};
                frame_total = 34'(r_base) + 34'(n_siglen);
                if (pos_x >= 34'(r_siglen_end)) begin
                    if (frame_total > 34'(limit)) begin
                        err   = ERR_TOO_LONG;
                        n_sec = SEC_HEADER;
                        n_pos = POS_ZERO;
                        adv   = 1'b0;
                    end else if (n_siglen == '0) begin
                        last  = 1'b1;
                        n_sec = SEC_HEADER;
                        n_pos = POS_ZERO;
                        adv   = 1'b0;
                    end else begin
                        n_sec = SEC_SIG;
                    end
                end
            end
            SEC_SIG: begin
                if (pos_x >= r_sig_end) begin
                    last  = 1'b1;
                    n_sec = SEC_HEADER;
                    n_pos = POS_ZERO;
                    adv   = 1'b0;
                end
            end
            default: begin
                n_sec = SEC_HEADER;
            end
        endcase

        if (adv) begin
            n_pos = r_pos + POS_ONE;
        end

        // Section end positions follow the lengths, so later bytes only compare.
        n_pay_end    = 33'(HDR_BYTES - 1) + 33'(n_plen);
        n_siglen_end = 33'(HDR_BYTES - 1 + LEN_BYTES) + 33'(n_plen);
        n_base       = 33'(HDR_BYTES + LEN_BYTES) + 33'(n_plen);
        n_sig_end    = 34'(r_siglen_end) + 34'(n_siglen);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec        <= SEC_HEADER;
            r_pos        <= '0;
            r_plen       <= '0;
            r_siglen     <= '0;
            r_pay_end    <= 33'(HDR_BYTES - 1);
            r_siglen_end <= 33'(HDR_BYTES - 1 + LEN_BYTES);
            r_base       <= 33'(HDR_BYTES + LEN_BYTES);
            r_sig_end    <= 34'(HDR_BYTES - 1 + LEN_BYTES);
        end else if (i_fire) begin
            r_sec        <= n_sec;
            r_pos        <= n_pos;
            r_plen       <= n_plen;
            r_siglen     <= n_siglen;
            r_pay_end    <= n_pay_end;
            r_siglen_end <= n_siglen_end;
            r_base       <= n_base;
            r_sig_end    <= n_sig_end;
        end
    end

    always_comb begin
        o_result.out_byte       = i_byte;
        o_result.section        = r_sec;
        o_result.first_of_frame = first;
        o_result.last_of_frame  = last;
        o_result.error_code     = err;
    end

endmodule

// ===== rtl/core/sedf_out_stage.sv =====
// Output result register that drives the master-side stream.
module sedf_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sedf_pkg::t_result i_result,
    output logic              o_adv,
    output logic              o_valid,
    input  logic              i_ready,
    output sedf_pkg::t_result o_result
);
    import sedf_pkg::*;

    logic    r_valid;
    t_result r_result;

    // The register takes a new beat when empty or when its beat is taken.
    assign o_adv = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/core/signed_envelope_deframer_core.sv =====
// Top level of the signed envelope deframer: ports, configuration and stages.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[7:0] received byte
//  m_axis    out        tdata[7:0] byte, tuser section/first/error, tlast frame end
//  cfg       in         i_cfg_idx 0 expected version, 1 max frame bytes
//
// Each byte is held in the input register while the parser tags it, then
// registered in the output register, from which it is offered on m_axis.
// One byte is accepted every cycle while m_axis does not stall; the
// per-byte work is a counter update plus the section-end adds and compares
// against the section ends and the frame limit. Reset is synchronous and
// active low and returns the parser to the start of a frame. A stall on
// m_axis backs up through both registers to s_axis_tready.
module signed_envelope_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // Byte input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // Tagged byte output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [4:0]  m_axis_tuser,   // [1:0] section, [2] first_of_frame, [4:3] error_code
    output logic        m_axis_tlast    // last_of_frame
);
    import sedf_pkg::*;

    logic [7:0]  r_exp_ver;
    logic [31:0] r_max_bytes;
    t_cfg        cfg;

    logic        in_valid;
    logic [7:0]  in_byte;
    logic        out_adv;
    logic        fire;
    t_result     parse_result;
    t_result     out_result;

    // Configuration registers; the user must write them only while the stream is idle (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver   <= EXP_VER_RST;
            r_max_bytes <= MAX_BYTES_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_EXP_VER) begin
                r_exp_ver <= i_cfg_data[7:0];
            end else if (i_cfg_idx == CFG_MAX_BYTES) begin
                r_max_bytes <= i_cfg_data;
            end
        end
    end

    assign cfg.exp_ver   = r_exp_ver;
    assign cfg.max_bytes = r_max_bytes;

    // The parser consumes a held byte whenever the output register can load.
    assign fire = in_valid && out_adv;

    sedf_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .o_valid (in_valid),
        .i_take  (out_adv),
        .o_byte  (in_byte)
    );

    sedf_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (in_byte),
        .i_cfg    (cfg),
        .o_result (parse_result)
    );

    sedf_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_valid),
        .i_result (parse_result),
        .o_adv    (out_adv),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = out_result.out_byte;
    assign m_axis_tuser = {out_result.error_code, out_result.first_of_frame,
                           out_result.section};
    assign m_axis_tlast = out_result.last_of_frame;

endmodule

// ===== rtl/core/sedf_checker.sv =====
// Port-level checks for the signed envelope deframer, bound to the top level.
module sedf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [4:0] m_axis_tuser,
    input logic       m_axis_tlast
);
    import sedf_pkg::*;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A frame end never carries an error.
    a_last_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[4:3] == ERR_NONE))
        else $error("frame end flagged with an error");

    // A frame start and a version error both sit on the header's first byte.
    a_first_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |->
        (m_axis_tuser[1:0] == SEC_HEADER && m_axis_tuser[4:3] == ERR_NONE
         && !m_axis_tlast))
        else $error("frame start outside header");

    a_ver_err_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[4:3] == ERR_VERSION) |->
        (m_axis_tuser[1:0] == SEC_HEADER && !m_axis_tuser[2]))
        else $error("version error outside header start");

    // A stalled beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast)))
        else $error("stalled output beat changed");

endmodule

bind signed_envelope_deframer_core sedf_checker u_sedf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
